>>> sv/http_date_parser_core_assert.svh
// Assertion macros used by the checker file of the date parser.
`ifndef HTTP_DATE_PARSER_CORE_ASSERT_SVH
`define HTTP_DATE_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define HDP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define HDP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/hdp_pkg.sv
`default_nettype none

package hdp_pkg;

    // Number of lexems kept per date string
    localparam int MAX_LEXEMS  = 7;
    localparam int LEX_CNT_W   = 3;
    localparam int LEX_LEN_MAX = 7;

    // Character codes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_T      = 8'h54;

    // Year handling
    localparam int YEAR_BASE      = 1900;
    localparam int YEAR_SHORT_MAX = 99;

    // Output field widths
    localparam int FIELD_W = 20;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 21;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_NUMBER = 2'd1,
        STATUS_BAD_MONTH  = 2'd2,
        STATUS_TOO_FEW    = 2'd3
    } status_t;

    typedef struct packed {
        logic               ok;
        logic [MONTH_W-1:0] idx;
    } month_match_t;

    localparam logic [23:0] MONTH_NAMES [12] = '{
        24'h4A616E, 24'h466562, 24'h4D6172, 24'h417072, 24'h4D6179, 24'h4A756E,
        24'h4A756C, 24'h417567, 24'h536570, 24'h4F6374, 24'h4E6F76, 24'h446563
    };

    // Case-sensitive three-letter month lookup
    function automatic month_match_t month_lookup(input logic [23:0] name);
        month_match_t res;
        res.ok  = 1'b0;
        res.idx = '0;
        for (int m = 0; m < 12; m++) begin
            if (MONTH_NAMES[m] == name) begin
                res.ok  = 1'b1;
                res.idx = MONTH_W'(m);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> sv/hdp_char_if.sv
`default_nettype none

interface hdp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink (input valid, input char_code, input is_last, output ready);
endinterface

`default_nettype wire

>>> sv/hdp_date_if.sv
`default_nettype none

interface hdp_date_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [19:0]        seconds;
    logic [19:0]        minutes;
    logic [19:0]        hours;
    logic [19:0]        day_of_month;
    logic [3:0]         month_index;
    logic signed [20:0] year_offset;

    modport source (
        output valid, output status, output seconds, output minutes, output hours,
        output day_of_month, output month_index, output year_offset, input ready
    );
    modport sink (
        input valid, input status, input seconds, input minutes, input hours,
        input day_of_month, input month_index, input year_offset, output ready
    );
endinterface

`default_nettype wire

>>> sv/hdp_lexer.sv
`default_nettype none

module hdp_lexer
    import hdp_pkg::*;
#(
    parameter int VALUE_BITS = 20,
    parameter int SLOT_W     = VALUE_BITS + 6,
    parameter int JOB_W      = MAX_LEXEMS * SLOT_W + LEX_CNT_W + 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    hdp_char_if.sink              char_in,
    output logic                  push_valid,
    input  wire logic             push_ready,
    output logic [JOB_W-1:0]      push_data
);

    localparam int ACC_W = VALUE_BITS + 4;
    localparam logic [ACC_W-1:0] VALUE_MAX = ACC_W'((64'd1 << VALUE_BITS) - 64'd1);

    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic                  ok_reg, ok_next;
    logic [2:0]            len_reg, len_next;
    logic [23:0]           name_reg, name_next;
    logic                  prev_delim_reg, prev_delim_next;
    logic [LEX_CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0]     slots_reg [MAX_LEXEMS];

    logic                  accept;
    logic                  delim;
    logic                  digit;
    logic [ACC_W-1:0]      acc;
    logic                  over;
    logic [VALUE_BITS-1:0] value_upd;
    logic                  ok_upd;
    logic [2:0]            len_upd;
    logic [23:0]           name_upd;
    logic                  do_close;
    logic                  has_room;
    logic [VALUE_BITS-1:0] src_value;
    logic                  src_ok;
    logic [2:0]            src_len;
    logic [23:0]           src_name;
    month_match_t          mon;
    logic [SLOT_W-1:0]     new_slot;

    assign char_in.ready = push_ready;
    assign accept = char_in.valid && push_ready;

    // Character classes
    assign delim = (char_in.char_code == CH_SPACE) || (char_in.char_code == CH_COMMA)
                || (char_in.char_code == CH_HYPHEN) || (char_in.char_code == CH_COLON);
    assign digit = (char_in.char_code >= CH_ZERO) && (char_in.char_code <= CH_NINE);

    // Lexem after taking a non-delimiter: decimal accumulate, saturating
    assign acc = (ACC_W'(value_reg) << 3) + (ACC_W'(value_reg) << 1)
               + ACC_W'(char_in.char_code[3:0]);
    assign over = acc > VALUE_MAX;
    assign value_upd = !digit ? value_reg
                     : (over ? VALUE_MAX[VALUE_BITS-1:0] : acc[VALUE_BITS-1:0]);
    assign ok_upd = ok_reg && digit && !over;
    assign len_upd = (len_reg < 3'(LEX_LEN_MAX)) ? len_reg + 3'd1 : len_reg;
    assign name_upd = {name_reg[15:0], char_in.char_code};

    // A delimiter closes the lexem before it; the last character closes its own
    assign do_close = delim ? !prev_delim_reg : char_in.is_last;
    assign has_room = count_reg < LEX_CNT_W'(MAX_LEXEMS);
    assign src_value = delim ? value_reg : value_upd;
    assign src_ok    = delim ? ok_reg : ok_upd;
    assign src_len   = delim ? len_reg : len_upd;
    assign src_name  = delim ? name_reg : name_upd;

    // Slot for the closing lexem: {month index, month ok, number ok, value}
    always_comb
    begin
        mon = month_lookup(src_name);
        if (src_len != 3'd3) begin
            mon.ok  = 1'b0;
            mon.idx = '0;
        end
        new_slot = {mon.idx, mon.ok, src_ok && (src_len != 3'd0), src_value};
    end

    // Job for the back end: slots with the final close folded in
    always_comb
    begin
        for (int i = 0; i < MAX_LEXEMS; i++) begin
            push_data[i*SLOT_W +: SLOT_W] =
                (do_close && (count_reg == LEX_CNT_W'(i))) ? new_slot : slots_reg[i];
        end
        push_data[MAX_LEXEMS*SLOT_W +: LEX_CNT_W] =
            count_reg + LEX_CNT_W'(do_close && has_room);
        push_data[JOB_W-1] = (char_in.char_code == CH_T);
    end

    assign push_valid = char_in.valid && char_in.is_last;

    // Stream state next values
    always_comb
    begin
        value_next      = value_reg;
        ok_next         = ok_reg;
        len_next        = len_reg;
        name_next       = name_reg;
        prev_delim_next = prev_delim_reg;
        count_next      = count_reg;
        if (accept) begin
            if (char_in.is_last) begin
                value_next      = '0;
                ok_next         = 1'b1;
                len_next        = '0;
                name_next       = '0;
                prev_delim_next = 1'b0;
                count_next      = '0;
            end else if (delim) begin
                value_next      = '0;
                ok_next         = 1'b1;
                len_next        = '0;
                name_next       = '0;
                prev_delim_next = 1'b1;
                if (do_close && has_room) begin
                    count_next = count_reg + LEX_CNT_W'(1);
                end
            end else begin
                value_next      = value_upd;
                ok_next         = ok_upd;
                len_next        = len_upd;
                name_next       = name_upd;
                prev_delim_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            value_reg      <= '0;
            ok_reg         <= 1'b1;
            len_reg        <= '0;
            name_reg       <= '0;
            prev_delim_reg <= 1'b0;
            count_reg      <= '0;
        end else begin
            value_reg      <= value_next;
            ok_reg         <= ok_next;
            len_reg        <= len_next;
            name_reg       <= name_next;
            prev_delim_reg <= prev_delim_next;
            count_reg      <= count_next;
        end
    end

    // Slot store, written at the lexem count
    always_ff @(posedge clk)
    begin
        if (accept && do_close && has_room && !char_in.is_last) begin
            slots_reg[count_reg] <= new_slot;
        end
    end

endmodule

`default_nettype wire

>>> sv/hdp_queue.sv
`default_nettype none

module hdp_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    // Two-entry FIFO between lexer and evaluator
    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       fill_reg, fill_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> sv/hdp_eval.sv
`default_nettype none

module hdp_eval
    import hdp_pkg::*;
#(
    parameter int VALUE_BITS = 20,
    parameter int SLOT_W     = VALUE_BITS + 6,
    parameter int JOB_W      = MAX_LEXEMS * SLOT_W + LEX_CNT_W + 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             job_valid,
    output logic                  job_ready,
    input  wire logic [JOB_W-1:0] job_data,
    hdp_date_if.source            date_out
);

    localparam int EXT_W = (VALUE_BITS > FIELD_W) ? VALUE_BITS : FIELD_W;
    localparam int YW    = (VALUE_BITS + 2 > YEAR_W) ? VALUE_BITS + 2 : YEAR_W;

    logic [VALUE_BITS-1:0] val [MAX_LEXEMS];
    logic                  num_ok [MAX_LEXEMS];
    logic                  mon_ok [MAX_LEXEMS];
    logic [MONTH_W-1:0]    mon_idx [MAX_LEXEMS];
    status_t               err [MAX_LEXEMS];
    logic [LEX_CNT_W-1:0]  count;
    logic                  gmt;
    status_t               status_c;

    logic [VALUE_BITS-1:0] day_v, hour_v, min_v, sec_v, year_v;
    logic [MONTH_W-1:0]    month_v;
    logic [EXT_W-1:0]      day_e, hour_e, min_e, sec_e;
    logic [YW-1:0]         year_e, year_sub;
    logic [YEAR_W-1:0]     year_c;

    logic                  out_valid_reg;
    status_t               status_reg;
    logic [FIELD_W-1:0]    sec_reg, min_reg, hour_reg, day_reg;
    logic [MONTH_W-1:0]    month_reg;
    logic [YEAR_W-1:0]     year_reg;
    logic                  load;

    // Unpack the job
    always_comb
    begin
        for (int i = 0; i < MAX_LEXEMS; i++) begin
            val[i]     = job_data[i*SLOT_W +: VALUE_BITS];
            num_ok[i]  = job_data[i*SLOT_W + VALUE_BITS];
            mon_ok[i]  = job_data[i*SLOT_W + VALUE_BITS + 1];
            mon_idx[i] = job_data[i*SLOT_W + VALUE_BITS + 2 +: MONTH_W];
        end
        count = job_data[MAX_LEXEMS*SLOT_W +: LEX_CNT_W];
        gmt   = job_data[JOB_W-1];
    end

    // Per-position error code; the month is the third lexem in GMT order and
    // the second in asctime order, and the day name is never checked
    always_comb
    begin
        for (int i = 0; i < MAX_LEXEMS; i++) begin
            err[i] = STATUS_OK;
            if (i != 0) begin
                if ((gmt && (i == 2)) || (!gmt && (i == 1))) begin
                    if (!mon_ok[i]) err[i] = STATUS_BAD_MONTH;
                end else if (!num_ok[i]) begin
                    err[i] = STATUS_BAD_NUMBER;
                end
            end
        end
    end

    // First failing kept lexem wins, else too few lexems
    always_comb
    begin
        status_c = (count < LEX_CNT_W'(MAX_LEXEMS)) ? STATUS_TOO_FEW : STATUS_OK;
        for (int i = MAX_LEXEMS - 1; i >= 0; i--) begin
            if ((LEX_CNT_W'(i) < count) && (err[i] != STATUS_OK)) begin
                status_c = err[i];
            end
        end
    end

    // Field selection by token order
    always_comb
    begin
        if (gmt) begin
            day_v   = val[1];
            month_v = mon_idx[2];
            year_v  = val[3];
            hour_v  = val[4];
            min_v   = val[5];
            sec_v   = val[6];
        end else begin
            month_v = mon_idx[1];
            day_v   = val[2];
            hour_v  = val[3];
            min_v   = val[4];
            sec_v   = val[5];
            year_v  = val[6];
        end
        day_e    = EXT_W'(day_v);
        hour_e   = EXT_W'(hour_v);
        min_e    = EXT_W'(min_v);
        sec_e    = EXT_W'(sec_v);
        year_e   = YW'(year_v);
        year_sub = year_e - YW'(YEAR_BASE);
        year_c   = (year_e > YW'(YEAR_SHORT_MAX)) ? year_sub[YEAR_W-1:0]
                                                  : year_e[YEAR_W-1:0];
    end

    // Output register
    assign load      = job_valid && (!out_valid_reg || date_out.ready);
    assign job_ready = !out_valid_reg || date_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
        end else if (date_out.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            status_reg <= status_c;
            if (status_c == STATUS_OK) begin
                sec_reg   <= sec_e[FIELD_W-1:0];
                min_reg   <= min_e[FIELD_W-1:0];
                hour_reg  <= hour_e[FIELD_W-1:0];
                day_reg   <= day_e[FIELD_W-1:0];
                month_reg <= month_v;
                year_reg  <= year_c;
            end else begin
                sec_reg   <= '0;
                min_reg   <= '0;
                hour_reg  <= '0;
                day_reg   <= '0;
                month_reg <= '0;
                year_reg  <= '0;
            end
        end
    end

    assign date_out.valid        = out_valid_reg;
    assign date_out.status       = status_reg;
    assign date_out.seconds      = sec_reg;
    assign date_out.minutes      = min_reg;
    assign date_out.hours        = hour_reg;
    assign date_out.day_of_month = day_reg;
    assign date_out.month_index  = month_reg;
    assign date_out.year_offset  = $signed(year_reg);

endmodule

`default_nettype wire

>>> sv/http_date_parser_core.sv
// HTTP date parser core.
// char_in takes one character per beat (char_code, is_last); date_out gives
// one broken-down date per string, issued after the beat that has is_last set.
// Throughput: one character per cycle while the job queue has room. The lexer
// keeps all stream state and folds the final character in the same cycle it
// is taken. After the final character's beat, the job passes through the job
// queue, then the evaluator's output register, before the date beat is valid.
// A two-entry job queue sits between lexer and evaluator; if date_out is
// stalled and the queue fills, char_in.ready drops until a date is taken.
// Up to two finished dates can wait while the next string streams in.
// Reset (rst_n low, asynchronous) empties the queue, drops date_out.valid and
// starts a fresh string; no clearing pass is needed.
// Non-zero status means every other field of the date beat is zero.
`default_nettype none

module http_date_parser_core
    import hdp_pkg::*;
#(
    parameter int VALUE_BITS = 20
) (
    input  wire logic clk,
    input  wire logic rst_n,
    hdp_char_if.sink   char_in,
    hdp_date_if.source date_out
);

    localparam int SLOT_W = VALUE_BITS + 6;
    localparam int JOB_W  = MAX_LEXEMS * SLOT_W + LEX_CNT_W + 1;

    logic             push_valid;
    logic             push_ready;
    logic [JOB_W-1:0] push_data;
    logic             pop_valid;
    logic             pop_ready;
    logic [JOB_W-1:0] pop_data;

    hdp_lexer #(
        .VALUE_BITS (VALUE_BITS),
        .SLOT_W     (SLOT_W),
        .JOB_W      (JOB_W)
    ) u_lexer (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_in),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    hdp_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    hdp_eval #(
        .VALUE_BITS (VALUE_BITS),
        .SLOT_W     (SLOT_W),
        .JOB_W      (JOB_W)
    ) u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job_data  (pop_data),
        .date_out  (date_out)
    );

endmodule

`default_nettype wire

>>> sv/hdp_checker.sv
`default_nettype none
`include "http_date_parser_core_assert.svh"

module hdp_checker
    import hdp_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [1:0]        status,
    input wire logic [19:0]       seconds,
    input wire logic [19:0]       minutes,
    input wire logic [19:0]       hours,
    input wire logic [19:0]       day_of_month,
    input wire logic [3:0]        month_index,
    input wire logic signed [20:0] year_offset
);

    // Date fields beside the status, packed for the checks
    logic [104:0] fields;

    assign fields = {seconds, minutes, hours, day_of_month, month_index, year_offset};

    // A stalled date beat stays up
    `HDP_ASSERT_NEXT(a_valid_hold, out_valid && !out_ready, out_valid, "date beat dropped")

    // A stalled date beat keeps its payload
    `HDP_ASSERT_NEXT(a_payload_hold, out_valid && !out_ready, $stable(status) && $stable(fields), "date payload changed")

    // Error beats carry zero fields
    `HDP_ASSERT_NOW(a_err_zero, out_valid && (status != STATUS_OK), fields == '0, "error beat with fields")

    // Good dates name a real month
    `HDP_ASSERT_NOW(a_month_range, out_valid && (status == STATUS_OK), month_index <= 4'd11, "month index out of range")

endmodule

bind http_date_parser_core hdp_checker u_hdp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (date_out.valid),
    .out_ready    (date_out.ready),
    .status       (date_out.status),
    .seconds      (date_out.seconds),
    .minutes      (date_out.minutes),
    .hours        (date_out.hours),
    .day_of_month (date_out.day_of_month),
    .month_index  (date_out.month_index),
    .year_offset  (date_out.year_offset)
);

`default_nettype wire

>>> tb/hdp_date_checker.sv
`default_nettype none

// Watches both channels of the date parser, rebuilds the lexer state from
// every accepted character beat and checks each date beat against the oldest
// predicted date.
module hdp_date_checker
    import hdp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    hdp_char_if       char_mon,
    hdp_date_if       date_mon,
    output int        fail_count,
    output int        dates_pending,
    output int        dates_checked
);

    localparam int VALUE_BITS = 20;
    localparam longint unsigned VALUE_LIMIT = (64'd1 << VALUE_BITS) - 1;

    typedef enum logic [2:0] {
        TOK_DAYNAME,
        TOK_DAY,
        TOK_MONTH,
        TOK_YEAR,
        TOK_HOURS,
        TOK_MINUTES,
        TOK_SECONDS
    } token_t;

    // Token order per position, position 0 in the low bits
    localparam logic [3*MAX_LEXEMS-1:0] GMT_ORDER = {
        TOK_SECONDS, TOK_MINUTES, TOK_HOURS, TOK_YEAR, TOK_MONTH, TOK_DAY, TOK_DAYNAME
    };
    localparam logic [3*MAX_LEXEMS-1:0] ASC_ORDER = {
        TOK_YEAR, TOK_SECONDS, TOK_MINUTES, TOK_HOURS, TOK_DAY, TOK_MONTH, TOK_DAYNAME
    };

    typedef struct {
        longint unsigned value;
        bit              num_ok;
        bit              mon_ok;
        logic [3:0]      mon;
    } lexem_slot_t;

    typedef struct {
        status_t            status;
        logic [19:0]        seconds;
        logic [19:0]        minutes;
        logic [19:0]        hours;
        logic [19:0]        day_of_month;
        logic [3:0]         month_index;
        logic signed [20:0] year_offset;
    } date_t;

    // Lexer state of the string in flight
    longint unsigned acc_value;
    bit              acc_digits_ok;
    int              acc_len;
    logic [23:0]     acc_name;
    bit              after_delim;
    int              lexem_total;
    lexem_slot_t     slots [MAX_LEXEMS];

    date_t date_q [$];
    int    errors;
    int    checked;

    task automatic report(input string msg);
        errors++;
        $display("[%0t] date check: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            report($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    task automatic clear_lexem();
        acc_value     = 0;
        acc_digits_ok = 1'b1;
        acc_len       = 0;
        acc_name      = '0;
    endtask

    // Store the current lexem if there is room, then start a new one
    task automatic close_lexem();
        if (lexem_total < MAX_LEXEMS) begin
            slots[lexem_total].value  = acc_value;
            slots[lexem_total].num_ok = acc_digits_ok && acc_len != 0;
            slots[lexem_total].mon_ok = 1'b0;
            slots[lexem_total].mon    = '0;
            if (acc_len == 3) begin
                for (int m = 0; m < 12; m++) begin
                    if (MONTH_NAMES[m] == acc_name) begin
                        slots[lexem_total].mon_ok = 1'b1;
                        slots[lexem_total].mon    = 4'(m);
                    end
                end
            end
            lexem_total++;
        end
        clear_lexem();
    endtask

    always @(posedge clk or negedge rst_n) begin : track
        date_t                   want;
        logic [7:0]              c;
        logic [3*MAX_LEXEMS-1:0] order;
        token_t                  tok;
        status_t                 st;
        longint                  yr;
        if (!rst_n) begin
            clear_lexem();
            after_delim = 1'b0;
            lexem_total = 0;
            date_q.delete();
            errors  = 0;
            checked = 0;
            fail_count    <= 0;
            dates_pending <= 0;
            dates_checked <= 0;
        end
        else begin
            // fold an accepted character into the lexer state
            if (char_mon.valid && char_mon.ready) begin
                c = char_mon.char_code;
                if (c == CH_SPACE || c == CH_COMMA || c == CH_HYPHEN || c == CH_COLON) begin
                    // a run of delimiters closes one lexem only
                    if (!after_delim)
                        close_lexem();
                    after_delim = 1'b1;
                end
                else begin
                    after_delim = 1'b0;
                    if (acc_len < LEX_LEN_MAX)
                        acc_len++;
                    acc_name = {acc_name[15:0], c};
                    if (c >= CH_ZERO && c <= CH_NINE) begin
                        acc_value = acc_value * 10 + longint'(c - CH_ZERO);
                        if (acc_value > VALUE_LIMIT) begin
                            acc_value     = VALUE_LIMIT;
                            acc_digits_ok = 1'b0;
                        end
                    end
                    else begin
                        acc_digits_ok = 1'b0;
                    end
                end

                // final character: choose token order, build the expected date
                if (char_mon.is_last) begin
                    if (!after_delim)
                        close_lexem();
                    order              = (c == CH_T) ? GMT_ORDER : ASC_ORDER;
                    st                 = STATUS_OK;
                    want.seconds       = '0;
                    want.minutes       = '0;
                    want.hours         = '0;
                    want.day_of_month  = '0;
                    want.month_index   = '0;
                    want.year_offset   = '0;
                    for (int i = 0; i < lexem_total && st == STATUS_OK; i++) begin
                        tok = token_t'(order[i*3 +: 3]);
                        if (tok == TOK_MONTH) begin
                            if (!slots[i].mon_ok)
                                st = STATUS_BAD_MONTH;
                            else
                                want.month_index = slots[i].mon;
                        end
                        else if (tok != TOK_DAYNAME) begin
                            if (!slots[i].num_ok)
                                st = STATUS_BAD_NUMBER;
                            else begin
                                case (tok)
                                    TOK_DAY:     want.day_of_month = 20'(slots[i].value);
                                    TOK_HOURS:   want.hours        = 20'(slots[i].value);
                                    TOK_MINUTES: want.minutes      = 20'(slots[i].value);
                                    TOK_SECONDS: want.seconds      = 20'(slots[i].value);
                                    default:
                                    begin
                                        yr = longint'(slots[i].value);
                                        if (yr > YEAR_SHORT_MAX)
                                            yr -= YEAR_BASE;
                                        want.year_offset = 21'(yr);
                                    end
                                endcase
                            end
                        end
                    end
                    if (st == STATUS_OK && lexem_total < MAX_LEXEMS)
                        st = STATUS_TOO_FEW;
                    // any error zeroes the rest of the date
                    if (st != STATUS_OK) begin
                        want.seconds      = '0;
                        want.minutes      = '0;
                        want.hours        = '0;
                        want.day_of_month = '0;
                        want.month_index  = '0;
                        want.year_offset  = '0;
                    end
                    want.status = st;
                    date_q.push_back(want);
                    clear_lexem();
                    after_delim = 1'b0;
                    lexem_total = 0;
                end
            end

            // compare an accepted date beat with the oldest prediction
            if (date_mon.valid && date_mon.ready) begin
                if (date_q.size() == 0)
                    report("date beat with no string pending");
                else begin
                    want = date_q.pop_front();
                    checked++;
                    compare_field("status", date_mon.status, want.status);
                    compare_field("seconds", date_mon.seconds, want.seconds);
                    compare_field("minutes", date_mon.minutes, want.minutes);
                    compare_field("hours", date_mon.hours, want.hours);
                    compare_field("day_of_month", date_mon.day_of_month, want.day_of_month);
                    compare_field("month_index", date_mon.month_index, want.month_index);
                    compare_field("year_offset", date_mon.year_offset, want.year_offset);
                end
            end

            fail_count    <= errors;
            dates_pending <= date_q.size();
            dates_checked <= checked;
        end
    end

endmodule

`default_nettype wire

>>> tb/http_date_parser_core_tb.sv
`default_nettype none

module http_date_parser_core_tb;
    import hdp_pkg::*;

    localparam int CHAR_TARGET  = 800;
    localparam int MIN_STRINGS  = 48;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 10;

    logic clk;
    logic rst_n;

    hdp_char_if char_bus ();
    hdp_date_if date_bus ();

    int fail_count;
    int dates_pending;
    int dates_checked;

    http_date_parser_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_in  (char_bus),
        .date_out (date_bus)
    );

    hdp_date_checker i_date_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_mon      (char_bus),
        .date_mon      (date_bus),
        .fail_count    (fail_count),
        .dates_pending (dates_pending),
        .dates_checked (dates_checked)
    );

    logic [7:0] text_q [$];
    int         chars_sent;
    int         strings_sent;
    bit         idle_on;
    int         hold_asked;
    int         hold_done;

    string seps = " ,-:";
    string month_words [12] = '{"Jan", "Feb", "Mar", "Apr", "May", "Jun",
                                "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"};
    string month_misses [6] = '{"jan", "JAN", "Janu", "Ja", "Xyz", "Sept"};
    string day_words [14] = '{"Mon", "Tue", "Wed", "Thu", "Fri", "Sat", "Sun",
                              "Monday", "Tuesday", "Wednesday", "Thursday",
                              "Friday", "Saturday", "Sunday"};
    string bad_numbers [5] = '{"+1", "1a", "x", "12b3", "9."};
    string directed [8] = '{
        "Sun, 06 Nov 1994 08:49:37 GMT",
        "Sunday, 06-Nov-94 08:49:37 GMT",
        "Sun Nov  6 08:49:37 1994",
        ",1 Dec 1048575 0:0:0 T",
        "x 1 Jan 1048576 1 2 3 T",
        "x 1 jan 99 1 2 3 T",
        "x 1 Jan 1 T",
        "x Feb 1 2 3 4 1850 :"
    };

    // Clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    task automatic put(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    task automatic put_sep();
        text_q.push_back(seps[$urandom_range(0, 3)]);
        if ($urandom_range(0, 9) < 2)
            text_q.push_back(seps[$urandom_range(0, 3)]);
    endtask

    function automatic string num_text();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $sformatf("%02d", $urandom_range(0, 99));
        else if (r < 75)
            return $sformatf("%0d", $urandom_range(0, 1048575));
        else if (r < 80)
            return ($urandom_range(0, 1) != 0) ? "1048575" : "1048576";
        else if (r < 85)
            return $sformatf("%0d", $urandom_range(1048576, 32'h0FFF_FFFF));
        else if (r < 88)
            return $sformatf("0000000%0d", $urandom_range(0, 999));
        else if (r < 97)
            return $sformatf("%0d", $urandom_range(1800, 2100));
        else
            return bad_numbers[$urandom_range(0, 4)];
    endfunction

    function automatic string year_text();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return $sformatf("%0d", $urandom_range(1900, 2099));
        else if (r < 75)
            return $sformatf("%02d", $urandom_range(0, 99));
        else
            return num_text();
    endfunction

    function automatic string month_text();
        if ($urandom_range(0, 9) == 0)
            return month_misses[$urandom_range(0, 5)];
        return month_words[$urandom_range(0, 11)];
    endfunction

    // Well-formed GMT or asctime date with random content
    task automatic make_date();
        bit gmt;
        gmt = $urandom_range(0, 1);
        if ($urandom_range(0, 19) == 0)
            put_sep();
        put(day_words[$urandom_range(0, 13)]);
        put_sep();
        if (gmt) begin
            put(num_text());
            put_sep();
            put(month_text());
            put_sep();
            put(year_text());
        end
        else begin
            put(month_text());
            put_sep();
            put(num_text());
        end
        put_sep();
        put(num_text());
        put_sep();
        put(num_text());
        put_sep();
        put(num_text());
        // an extra lexem; in GMT order it falls past the kept ones
        if ($urandom_range(0, 9) == 0) begin
            put_sep();
            put(num_text());
        end
        put_sep();
        if (gmt) begin
            if ($urandom_range(0, 1) != 0)
                put("GMT");
            else
                put("T");
        end
        else begin
            put(year_text());
            if ($urandom_range(0, 9) == 0)
                put_sep();
        end
    endtask

    // Short string of arbitrary bytes
    task automatic make_noise();
        int len;
        int r;
        len = $urandom_range(1, 14);
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40)
                text_q.push_back(8'($urandom_range(0, 255)));
            else if (r < 60)
                text_q.push_back(seps[$urandom_range(0, 3)]);
            else if (r < 85)
                text_q.push_back(8'($urandom_range(48, 57)));
            else
                text_q.push_back(8'($urandom_range(65, 122)));
        end
        if ($urandom_range(0, 2) == 0)
            text_q[len-1] = CH_T;
    endtask

    // Send the queued string, one beat per character, last beat flagged
    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++) begin
            while (idle_on && $urandom_range(0, 99) < 28) begin
                char_bus.valid <= 1'b0;
                @(posedge clk);
            end
            char_bus.valid     <= 1'b1;
            char_bus.char_code <= text_q[i];
            char_bus.is_last   <= (i == text_q.size() - 1);
            @(posedge clk);
            while (!char_bus.ready)
                @(posedge clk);
            chars_sent++;
        end
        text_q.delete();
        strings_sent++;
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        hold_done = 0;
        date_bus.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_done != hold_asked) begin
                hold_done = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                date_bus.ready <= 1'b0;
            end
            else
                date_bus.ready <= !idle_on || ($urandom_range(0, 99) >= 28);
        end
    end

    // Run limit
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("http_date_parser_core regression: fail");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        int rand_count;
        rand_count         = 0;
        chars_sent         = 0;
        strings_sent       = 0;
        hold_asked         = 0;
        idle_on            = 1'b1;
        rst_n              = 1'b0;
        char_bus.valid     = 1'b0;
        char_bus.char_code = '0;
        char_bus.is_last   = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed strings: all formats, errors, extremes, odd delimiters
        foreach (directed[k]) begin
            put(directed[k]);
            send_text();
        end

        // random strings, mostly well formed
        while (chars_sent < CHAR_TARGET || strings_sent < MIN_STRINGS) begin
            rand_count++;
            idle_on <= !(rand_count >= 8 && rand_count < 16);
            if (rand_count == 20)
                hold_asked <= hold_asked + 1;
            if ($urandom_range(0, 99) < 80)
                make_date();
            else
                make_noise();
            send_text();
        end
        char_bus.valid <= 1'b0;
        idle_on        <= 1'b1;

        // drain outstanding dates
        @(posedge clk);
        while (dates_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d characters in %0d strings: GMT and asctime dates, noise, long stall",
                 chars_sent, strings_sent);
        $display("compared %0d date beats, %0d mismatches", dates_checked, fail_count);
        if (fail_count == 0)
            $display("http_date_parser_core regression: pass");
        else
            $display("http_date_parser_core regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
